[hdl/cholesky_linear_solver_macros.svh]
// Assertion helpers for the solver controller.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef CHOLESKY_LINEAR_SOLVER_MACROS_SVH
`define CHOLESKY_LINEAR_SOLVER_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define CHOL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define CHOL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/chol_pkg.sv]
package chol_pkg;

    localparam int MAX_N     = 16;
    localparam int IDX_W     = $clog2(MAX_N);
    localparam int N_W       = IDX_W + 1;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int MAT_DEPTH = 1 << ADDR_W;
    localparam int Q_W       = 32;
    localparam int ACC_W     = 64;
    localparam int CFG_W     = 5;
    localparam int ST_W      = 2;

    localparam logic [Q_W-1:0]          Q_MAX    = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0]          Q_MIN    = 32'h8000_0000;
    localparam logic signed [ACC_W-1:0] NUM_LIM  = 64'sd70368744177664;
    localparam logic signed [ACC_W-1:0] SQRT_LIM = 64'sd281474976710655;

    // Result status codes.
    localparam logic [ST_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [ST_W-1:0] STATUS_NOT_SYM = 2'd1;
    localparam logic [ST_W-1:0] STATUS_NOT_PD  = 2'd2;

    // Which solve pass the sequencer is in.
    typedef enum logic [1:0] {
        PH_FAC = 2'd0,
        PH_FWD = 2'd1,
        PH_BCK = 2'd2
    } phase_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              coeff_we;
        logic [ADDR_W-1:0] c_waddr;
        logic              rhs_we;
        logic [IDX_W-1:0]  r_waddr;
        logic [ADDR_W-1:0] c_raddr0;
        logic [ADDR_W-1:0] c_raddr1;
        logic [ADDR_W-1:0] f_raddr0;
        logic [ADDR_W-1:0] f_raddr1;
        logic [IDX_W-1:0]  r_raddr;
        logic [IDX_W-1:0]  w_raddr0;
        logic [IDX_W-1:0]  w_raddr1;
        phase_t            phase;
        logic              acc_load;
        logic              mul_en;
        logic              acc_sub;
        logic              sqrt_start;
        logic              div_start;
        logic              fac_we;
        logic              fac_wsel_sqrt;
        logic [ADDR_W-1:0] f_waddr;
        logic              work_we;
        logic [IDX_W-1:0]  w_waddr;
        logic              out_load;
        logic              out_zero;
        logic [IDX_W-1:0]  out_index;
        logic [ST_W-1:0]   out_status;
        logic              out_last;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sym_eq;
        logic acc_nonpos;
        logic unit_busy;
        logic out_free;
    } sts_t;

endpackage

[hdl/cholesky_linear_solver.sv]
// Cholesky linear solver, signed Q16.16.
// Input channel (in_valid / in_stall / elem_value): the augmented system in row
// order, for each row the n matrix entries and then the right-hand-side entry.
// A transaction completes on a rising edge with in_valid high and in_stall low.
// Loads one entry per cycle unless stalled; in_stall is high while the block solves.
// Configuration channel (cfg_valid / cfg_ready / cfg_data): writes the system
// size n; cfg_ready is always high and a write restarts a partial load.
// Output channel (out_valid / out_stall): n solution transactions with sol_index
// and last on the final one, or a single error transaction (status 1 or 2).
// After the last entry the block checks symmetry, runs each multiply-accumulate in
// the shared multiplier and each square root and division in the serial units,
// then writes each result. The serial divider does most of the work (about
// n^2/2 + 2n divisions).
// The output register lets the next load start while the last result waits;
// a stalled receiver holds the solver until each result is taken.
// Reset empties the output register, clears the load position and sets n to 16.
module cholesky_linear_solver
    import chol_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [Q_W-1:0]   elem_value,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [Q_W-1:0]   sol_value,
    output logic [IDX_W-1:0] sol_index,
    output logic [ST_W-1:0]  status,
    output logic             last
);

    cmd_t cmd;
    sts_t sts;

    chol_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .sts(sts), .cmd(cmd)
    );

    chol_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .elem_value(elem_value), .out_stall(out_stall), .out_valid(out_valid),
        .sol_value(sol_value), .sol_index(sol_index), .status(status), .last(last)
    );

endmodule

[hdl/chol_ram.sv]
module chol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

[hdl/chol_dp.sv]
module chol_dp
    import chol_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    output sts_t             sts,
    input  logic [Q_W-1:0]   elem_value,
    input  logic             out_stall,
    output logic             out_valid,
    output logic [Q_W-1:0]   sol_value,
    output logic [IDX_W-1:0] sol_index,
    output logic [ST_W-1:0]  status,
    output logic             last
);

    logic [Q_W-1:0] coeff_rd0, coeff_rd1, fac_rd0, fac_rd1, rhs_rd, work_rd0, work_rd1;
    logic [Q_W-1:0] fac_wdata, sqrt_res, div_res;

    // Matrix, right-hand side, factor and work storage.
    chol_ram #(.WIDTH(Q_W), .DEPTH(MAT_DEPTH)) u_coeff (
        .clk(clk), .we(cmd.coeff_we), .waddr(cmd.c_waddr), .wdata(elem_value),
        .raddr0(cmd.c_raddr0), .raddr1(cmd.c_raddr1), .rdata0(coeff_rd0), .rdata1(coeff_rd1)
    );

    chol_ram #(.WIDTH(Q_W), .DEPTH(MAX_N)) u_rhs (
        .clk(clk), .we(cmd.rhs_we), .waddr(cmd.r_waddr), .wdata(elem_value),
        .raddr0(cmd.r_raddr), .raddr1(cmd.r_raddr), .rdata0(rhs_rd), .rdata1()
    );

    assign fac_wdata = cmd.fac_wsel_sqrt ? sqrt_res : div_res;

    chol_ram #(.WIDTH(Q_W), .DEPTH(MAT_DEPTH)) u_fac (
        .clk(clk), .we(cmd.fac_we), .waddr(cmd.f_waddr), .wdata(fac_wdata),
        .raddr0(cmd.f_raddr0), .raddr1(cmd.f_raddr1), .rdata0(fac_rd0), .rdata1(fac_rd1)
    );

    chol_ram #(.WIDTH(Q_W), .DEPTH(MAX_N)) u_work (
        .clk(clk), .we(cmd.work_we), .waddr(cmd.w_waddr), .wdata(div_res),
        .raddr0(cmd.w_raddr0), .raddr1(cmd.w_raddr1), .rdata0(work_rd0), .rdata1(work_rd1)
    );

    // Multiplier with a product register.
    logic signed [ACC_W-1:0] prod_reg;
    logic [Q_W-1:0]          mul_b;

    assign mul_b = (cmd.phase == PH_FAC) ? fac_rd1 : work_rd1;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= ACC_W'($signed(fac_rd0)) * ACC_W'($signed(mul_b));
        end
    end

    // Round the product to Q16.16, halves away from zero.
    logic [ACC_W-1:0]        prod_mag, rnd_mag;
    logic signed [ACC_W-1:0] prod_rnd;

    assign prod_mag = prod_reg[ACC_W-1] ? ACC_W'(-prod_reg) : ACC_W'(prod_reg);
    assign rnd_mag  = (prod_mag + ACC_W'(32'h8000)) >> 16;
    assign prod_rnd = prod_reg[ACC_W-1] ? -$signed(rnd_mag) : $signed(rnd_mag);

    // Accumulator: base value minus the sum of rounded products.
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] base;

    always_comb
    begin
        case (cmd.phase)
            PH_FAC:  base = ACC_W'($signed(coeff_rd0));
            PH_FWD:  base = ACC_W'($signed(rhs_rd));
            default: base = ACC_W'($signed(work_rd0));
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_load)
        begin
            acc_reg <= base;
        end
        else if (cmd.acc_sub)
        begin
            acc_reg <= acc_reg - prod_rnd;
        end
    end

    // Square root: two radicand bits per cycle.
    logic              sq_busy_reg;
    logic [5:0]        sq_cnt_reg;
    logic [ACC_W-1:0]  sq_rad_reg;
    logic [35:0]       sq_rem_reg;
    logic [Q_W-1:0]    sq_root_reg;
    logic [ACC_W-1:0]  sq_v;
    logic [35:0]       sq_rem2, sq_trial;

    assign sq_v     = (acc_reg > SQRT_LIM) ? SQRT_LIM : acc_reg;
    assign sq_rem2  = {sq_rem_reg[33:0], sq_rad_reg[ACC_W-1 -: 2]};
    assign sq_trial = {2'b00, sq_root_reg, 2'b01};
    assign sqrt_res = sq_root_reg[Q_W-1] ? Q_MAX : sq_root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_busy_reg <= 1'b0;
        end
        else if (cmd.sqrt_start)
        begin
            sq_busy_reg <= 1'b1;
        end
        else if (sq_busy_reg && sq_cnt_reg == 6'd1)
        begin
            sq_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            sq_rad_reg  <= {sq_v[47:0], 16'h0000};
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
            sq_cnt_reg  <= 6'd32;
        end
        else if (sq_busy_reg)
        begin
            sq_rad_reg <= {sq_rad_reg[ACC_W-3:0], 2'b00};
            sq_cnt_reg <= sq_cnt_reg - 6'd1;
            if (sq_rem2 >= sq_trial)
            begin
                sq_rem_reg  <= sq_rem2 - sq_trial;
                sq_root_reg <= {sq_root_reg[Q_W-2:0], 1'b1};
            end
            else
            begin
                sq_rem_reg  <= sq_rem2;
                sq_root_reg <= {sq_root_reg[Q_W-2:0], 1'b0};
            end
        end
    end

    // Divider: restoring, one quotient bit per cycle.
    logic              dv_busy_reg;
    logic [5:0]        dv_cnt_reg;
    logic [62:0]       dv_dq_reg;
    logic [Q_W-1:0]    dv_rem_reg;
    logic [Q_W-1:0]    dv_den_reg;
    logic              dv_neg_reg;
    logic signed [ACC_W-1:0] dv_num;
    logic [ACC_W-1:0]  dv_mag;
    logic [Q_W:0]      dv_rem2;
    logic              dv_qbit;

    always_comb
    begin
        if (acc_reg > NUM_LIM)
        begin
            dv_num = NUM_LIM;
        end
        else if (acc_reg < -NUM_LIM)
        begin
            dv_num = -NUM_LIM;
        end
        else
        begin
            dv_num = acc_reg;
        end
    end

    assign dv_mag  = dv_num[ACC_W-1] ? ACC_W'(-dv_num) : ACC_W'(dv_num);
    assign dv_rem2 = {dv_rem_reg, dv_dq_reg[62]};
    assign dv_qbit = (dv_rem2 >= {1'b0, dv_den_reg});

    always_comb
    begin
        if (!dv_neg_reg)
        begin
            div_res = (dv_dq_reg > 63'(Q_MAX)) ? Q_MAX : dv_dq_reg[Q_W-1:0];
        end
        else if (dv_dq_reg > 63'(Q_MIN))
        begin
            div_res = Q_MIN;
        end
        else
        begin
            div_res = -dv_dq_reg[Q_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_busy_reg <= 1'b0;
        end
        else if (cmd.div_start)
        begin
            dv_busy_reg <= 1'b1;
        end
        else if (dv_busy_reg && dv_cnt_reg == 6'd1)
        begin
            dv_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dv_dq_reg  <= {dv_mag[46:0], 16'h0000};
            dv_rem_reg <= '0;
            dv_den_reg <= fac_rd1;
            dv_neg_reg <= dv_num[ACC_W-1];
            dv_cnt_reg <= 6'd63;
        end
        else if (dv_busy_reg)
        begin
            dv_cnt_reg <= dv_cnt_reg - 6'd1;
            dv_dq_reg  <= {dv_dq_reg[61:0], dv_qbit};
            dv_rem_reg <= dv_qbit ? Q_W'(dv_rem2 - {1'b0, dv_den_reg}) : dv_rem2[Q_W-1:0];
        end
    end

    // Output register.
    logic             out_valid_reg;
    logic [Q_W-1:0]   sol_value_reg;
    logic [IDX_W-1:0] sol_index_reg;
    logic [ST_W-1:0]  status_reg;
    logic             last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            sol_value_reg <= cmd.out_zero ? '0 : work_rd0;
            sol_index_reg <= cmd.out_index;
            status_reg    <= cmd.out_status;
            last_reg      <= cmd.out_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign sol_value = sol_value_reg;
    assign sol_index = sol_index_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    // Status back to the controller.
    assign sts.sym_eq     = (coeff_rd0 == coeff_rd1);
    assign sts.acc_nonpos = (acc_reg <= 0);
    assign sts.unit_busy  = sq_busy_reg | dv_busy_reg;
    assign sts.out_free   = !out_valid_reg || !out_stall;

endmodule

[hdl/chol_ctrl.sv]
`include "cholesky_linear_solver_macros.svh"

module chol_ctrl
    import chol_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data,
    input  sts_t             sts,
    output cmd_t             cmd
);

    typedef enum logic [13:0] {
        S_LOAD    = 14'b00000000000001,
        S_SYM_RD  = 14'b00000000000010,
        S_SYM_CMP = 14'b00000000000100,
        S_BASE    = 14'b00000000001000,
        S_ACC0    = 14'b00000000010000,
        S_MRD     = 14'b00000000100000,
        S_MUL     = 14'b00000001000000,
        S_SUB     = 14'b00000010000000,
        S_END     = 14'b00000100000000,
        S_DIV     = 14'b00001000000000,
        S_WAIT    = 14'b00010000000000,
        S_OUT_RD  = 14'b00100000000000,
        S_OUT_WR  = 14'b01000000000000,
        S_ERR     = 14'b10000000000000
    } state_t;

    state_t           state_reg, state_next;
    phase_t           phase_reg, phase_next;
    logic [N_W-1:0]   i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [CFG_W-1:0] size_reg;
    logic [ST_W-1:0]  err_reg, err_next;
    logic [N_W-1:0]   n_eff, k_start, k_end;
    logic [IDX_W-1:0] ii, jj, kk;
    logic             accept;

    // Effective system size: zero acts as one, oversize as the maximum.
    always_comb
    begin
        if (size_reg == '0)
        begin
            n_eff = N_W'(1);
        end
        else if (size_reg > CFG_W'(MAX_N))
        begin
            n_eff = N_W'(MAX_N);
        end
        else
        begin
            n_eff = N_W'(size_reg);
        end
    end

    // A size write takes priority over a load transaction in the same cycle.
    assign ii        = i_reg[IDX_W-1:0];
    assign jj        = j_reg[IDX_W-1:0];
    assign kk        = k_reg[IDX_W-1:0];
    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_LOAD) || cfg_valid;
    assign accept    = in_valid && !in_stall;

    // Inner product range for each pass.
    always_comb
    begin
        case (phase_reg)
            PH_FAC:
            begin
                k_start = '0;
                k_end   = j_reg;
            end
            PH_FWD:
            begin
                k_start = '0;
                k_end   = i_reg;
            end
            default:
            begin
                k_start = i_reg + N_W'(1);
                k_end   = n_eff;
            end
        endcase
    end

    // Sequencer and command decode.
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        err_next   = err_reg;
        cmd        = '0;

        // Addresses follow the loop counters.
        cmd.c_waddr   = {ii, jj};
        cmd.r_waddr   = ii;
        cmd.c_raddr0  = {ii, jj};
        cmd.c_raddr1  = {jj, ii};
        cmd.f_raddr0  = (phase_reg == PH_BCK) ? {kk, ii} : {ii, kk};
        cmd.f_raddr1  = {jj, kk};
        cmd.r_raddr   = ii;
        cmd.w_raddr0  = ii;
        cmd.w_raddr1  = kk;
        cmd.phase     = phase_reg;
        cmd.f_waddr   = {ii, jj};
        cmd.w_waddr   = ii;
        cmd.out_index = ii;

        case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    cmd.coeff_we = (j_reg < n_eff);
                    cmd.rhs_we   = (j_reg == n_eff);
                    if (j_reg == n_eff)
                    begin
                        j_next = '0;
                        if (i_reg + N_W'(1) == n_eff)
                        begin
                            i_next     = '0;
                            state_next = S_SYM_RD;
                        end
                        else
                        begin
                            i_next = i_reg + N_W'(1);
                        end
                    end
                    else
                    begin
                        j_next = j_reg + N_W'(1);
                    end
                end
            end
            S_SYM_RD:
            begin
                state_next = S_SYM_CMP;
            end
            S_SYM_CMP:
            begin
                if (!sts.sym_eq)
                begin
                    err_next   = STATUS_NOT_SYM;
                    state_next = S_ERR;
                end
                else if (j_reg + N_W'(1) == n_eff)
                begin
                    j_next = '0;
                    if (i_reg + N_W'(1) == n_eff)
                    begin
                        i_next     = '0;
                        phase_next = PH_FAC;
                        state_next = S_BASE;
                    end
                    else
                    begin
                        i_next     = i_reg + N_W'(1);
                        state_next = S_SYM_RD;
                    end
                end
                else
                begin
                    j_next     = j_reg + N_W'(1);
                    state_next = S_SYM_RD;
                end
            end
            S_BASE:
            begin
                state_next = S_ACC0;
            end
            S_ACC0:
            begin
                cmd.acc_load = 1'b1;
                k_next       = k_start;
                state_next   = (k_start < k_end) ? S_MRD : S_END;
            end
            S_MRD:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_SUB;
            end
            S_SUB:
            begin
                cmd.acc_sub = 1'b1;
                k_next      = k_reg + N_W'(1);
                state_next  = (k_reg + N_W'(1) < k_end) ? S_MRD : S_END;
            end
            S_END:
            begin
                // Read the diagonal divisor.
                cmd.f_raddr1 = (phase_reg == PH_FAC) ? {jj, jj} : {ii, ii};
                if (phase_reg == PH_FAC && i_reg == j_reg)
                begin
                    if (sts.acc_nonpos)
                    begin
                        err_next   = STATUS_NOT_PD;
                        state_next = S_ERR;
                    end
                    else
                    begin
                        cmd.sqrt_start = 1'b1;
                        state_next     = S_WAIT;
                    end
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (!sts.unit_busy)
                begin
                    state_next = S_BASE;
                    case (phase_reg)
                        PH_FAC:
                        begin
                            cmd.fac_we        = 1'b1;
                            cmd.fac_wsel_sqrt = (i_reg == j_reg);
                            if (j_reg < i_reg)
                            begin
                                j_next = j_reg + N_W'(1);
                            end
                            else
                            begin
                                j_next = '0;
                                if (i_reg + N_W'(1) == n_eff)
                                begin
                                    i_next     = '0;
                                    phase_next = PH_FWD;
                                end
                                else
                                begin
                                    i_next = i_reg + N_W'(1);
                                end
                            end
                        end
                        PH_FWD:
                        begin
                            cmd.work_we = 1'b1;
                            if (i_reg + N_W'(1) == n_eff)
                            begin
                                i_next     = n_eff - N_W'(1);
                                phase_next = PH_BCK;
                            end
                            else
                            begin
                                i_next = i_reg + N_W'(1);
                            end
                        end
                        default:
                        begin
                            cmd.work_we = 1'b1;
                            if (i_reg == '0)
                            begin
                                state_next = S_OUT_RD;
                            end
                            else
                            begin
                                i_next = i_reg - N_W'(1);
                            end
                        end
                    endcase
                end
            end
            S_OUT_RD:
            begin
                state_next = S_OUT_WR;
            end
            S_OUT_WR:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = STATUS_OK;
                    cmd.out_last   = (i_reg + N_W'(1) == n_eff);
                    if (i_reg + N_W'(1) == n_eff)
                    begin
                        i_next     = '0;
                        j_next     = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        i_next     = i_reg + N_W'(1);
                        state_next = S_OUT_RD;
                    end
                end
            end
            S_ERR:
            begin
                cmd.out_index = '0;
                if (sts.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_zero   = 1'b1;
                    cmd.out_status = err_reg;
                    cmd.out_last   = 1'b1;
                    i_next         = '0;
                    j_next         = '0;
                    state_next     = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control registers. A size write restarts the load.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            phase_reg <= PH_FAC;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            err_reg   <= STATUS_OK;
            size_reg  <= CFG_W'(MAX_N);
        end
        else if (cfg_valid)
        begin
            size_reg  <= cfg_data;
            state_reg <= S_LOAD;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            err_reg   <= err_next;
        end
    end

    // Checks on the controller and datapath interplay.
    `CHOL_ASSERT_IMP(a_out_free, cmd.out_load, sts.out_free, "result loaded into a full output register")
    `CHOL_ASSERT_NXT(a_unit_start, cmd.sqrt_start || cmd.div_start, sts.unit_busy, "arithmetic unit did not start")
    `CHOL_ASSERT_IMP(a_write_done, cmd.fac_we || cmd.work_we, !sts.unit_busy, "result written before unit finished")

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
    import chol_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int unsigned SETTLE      = 200;

    typedef enum {SYS_SPD, SYS_ASYM, SYS_INDEF, SYS_NOISE} sys_kind_t;

    typedef struct packed {
        logic [Q_W-1:0]   value;
        logic [IDX_W-1:0] idx;
        logic [ST_W-1:0]  st;
        logic             lst;
    } solution_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_stall;
    logic [Q_W-1:0]   elem_value;
    logic             out_valid;
    logic             out_stall;
    logic [Q_W-1:0]   sol_value;
    logic [IDX_W-1:0] sol_index;
    logic [ST_W-1:0]  status;
    logic             last;

    cholesky_linear_solver u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .elem_value (elem_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sol_value  (sol_value),
        .sol_index  (sol_index),
        .status     (status),
        .last       (last)
    );

    // Stimulus and expectation storage.
    logic [Q_W-1:0] entry_queue[$];
    solution_t      solution_queue[$];

    // Shadow state of the solver.
    int          coef[MAX_N][MAX_N];
    int          rhs[MAX_N];
    int          fac[MAX_N][MAX_N];
    int          wvec[MAX_N];
    int unsigned entry_count;
    logic [CFG_W-1:0] size_reg;

    int unsigned errors;
    int unsigned cycles;
    int unsigned entries_taken;
    int unsigned results_checked;
    int unsigned systems_built;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    bit          offered;
    bit          cfg_done;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Q16.16 helpers for the shadow solver.
    function automatic int sat_q(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return int'(v);
    endfunction

    function automatic longint mul_q(int a, int b);
        longint p;
        longint unsigned mag;
        longint q;
        p   = longint'(a) * longint'(b);
        mag = (p < 0) ? longint'(-p) : p;
        q   = longint'((mag + 64'h8000) >> 16);
        return (p < 0) ? -q : q;
    endfunction

    function automatic int div_q(longint num, int den);
        if (den <= 0)
            return 0;
        if (num > NUM_LIM)
            num = NUM_LIM;
        if (num < -NUM_LIM)
            num = -NUM_LIM;
        return sat_q((num * 65536) / longint'(den));
    endfunction

    function automatic int root_q(longint v);
        longint unsigned x;
        longint unsigned r;
        longint unsigned bt;
        if (v <= 0)
            return 0;
        if (v > SQRT_LIM)
            v = SQRT_LIM;
        x  = longint'(v) << 16;
        r  = 0;
        bt = 64'd1 << 62;
        while (bt > x)
            bt = bt >> 2;
        while (bt != 0)
        begin
            if (x >= r + bt)
            begin
                x = x - (r + bt);
                r = (r >> 1) + bt;
            end
            else
                r = r >> 1;
            bt = bt >> 2;
        end
        return sat_q(longint'(r));
    endfunction

    function automatic int unsigned active_size();
        if (size_reg == 0)
            return 1;
        if (size_reg > MAX_N)
            return MAX_N;
        return size_reg;
    endfunction

    task automatic push_error(input logic [ST_W-1:0] code);
        solution_t s;
        s.value = '0;
        s.idx   = '0;
        s.st    = code;
        s.lst   = 1'b1;
        solution_queue.push_back(s);
    endtask

    // Symmetry check, factorization and both substitutions on the shadow copy.
    task automatic solve_system(input int unsigned n);
        longint    acc;
        longint    piv;
        solution_t s;
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                if (coef[i][j] != coef[j][i])
                begin
                    push_error(STATUS_NOT_SYM);
                    return;
                end
        for (int i = 0; i < n; i++)
            for (int j = 0; j <= i; j++)
            begin
                acc = 0;
                for (int k = 0; k < j; k++)
                    acc += mul_q(fac[i][k], fac[j][k]);
                if (i == j)
                begin
                    piv = longint'(coef[i][i]) - acc;
                    if (piv <= 0)
                    begin
                        push_error(STATUS_NOT_PD);
                        return;
                    end
                    fac[i][i] = root_q(piv);
                end
                else
                    fac[i][j] = div_q(longint'(coef[i][j]) - acc, fac[j][j]);
            end
        for (int i = 0; i < n; i++)
        begin
            acc = rhs[i];
            for (int j = 0; j < i; j++)
                acc -= mul_q(fac[i][j], wvec[j]);
            wvec[i] = div_q(acc, fac[i][i]);
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            acc = wvec[i];
            for (int j = i + 1; j < n; j++)
                acc -= mul_q(fac[j][i], wvec[j]);
            wvec[i] = div_q(acc, fac[i][i]);
        end
        for (int i = 0; i < n; i++)
        begin
            s.value = wvec[i];
            s.idx   = i[IDX_W-1:0];
            s.st    = STATUS_OK;
            s.lst   = (i == n - 1);
            solution_queue.push_back(s);
        end
    endtask

    // Stores one accepted entry and solves once the system is complete.
    task automatic load_entry(input int v);
        int unsigned n;
        int unsigned row;
        int unsigned col;
        n   = active_size();
        row = entry_count / (n + 1);
        col = entry_count % (n + 1);
        if (row >= n)
        begin
            entry_count = 0;
            row = 0;
            col = 0;
        end
        if (col < n)
            coef[row][col] = v;
        else
            rhs[row] = v;
        entry_count++;
        if (entry_count >= n * (n + 1))
        begin
            entry_count = 0;
            solve_system(n);
        end
    endtask

    // Monitor: input and configuration transactions feed the shadow solver,
    // output transactions are checked against the oldest expected solution.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                size_reg    = cfg_data;
                entry_count = 0;
                cfg_done    = 1'b1;
            end
            if (in_valid && !in_stall)
            begin
                load_entry(int'(elem_value));
                void'(entry_queue.pop_front());
                entries_taken++;
                offered = 1'b0;
            end
            if (out_valid && !out_stall)
            begin
                if (solution_queue.size() == 0)
                    report_mismatch("unexpected result, sol_index", sol_index, -1);
                else
                begin
                    solution_t e;
                    e = solution_queue.pop_front();
                    if (sol_value !== e.value)
                        report_mismatch("sol_value", longint'($signed(sol_value)),
                                        longint'($signed(e.value)));
                    if (sol_index !== e.idx)
                        report_mismatch("sol_index", sol_index, e.idx);
                    if (status !== e.st)
                        report_mismatch("status", status, e.st);
                    if (last !== e.lst)
                        report_mismatch("last", last, e.lst);
                end
                results_checked++;
            end
        end
    end

    // Driver: offers the oldest pending entry and holds it until it is taken.
    always @(negedge clk)
    begin
        if (rst_n && !offered)
        begin
            if (entry_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid   <= 1'b1;
                elem_value <= entry_queue[0];
                offered    = 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
        out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    // Run watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_size(input logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        cfg_done  = 1'b0;
        wait (cfg_done);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Waits for every entry to be taken and every solution to arrive.
    task automatic drain();
        wait (entry_queue.size() == 0 && solution_queue.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic int rand_span(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // Builds one augmented system of the given shape and queues it row by row.
    task automatic queue_system(input int unsigned n, input sys_kind_t kind);
        int     m[MAX_N][MAX_N];
        int     b[MAX_N];
        longint rowsum;
        int     bad;
        for (int i = 0; i < n; i++)
        begin
            for (int j = 0; j < i; j++)
            begin
                m[i][j] = rand_span(3 * 65536);
                m[j][i] = m[i][j];
            end
            b[i] = ($urandom_range(7) == 0) ? int'($urandom) : rand_span(20 * 65536);
        end
        for (int i = 0; i < n; i++)
        begin
            rowsum = 0;
            for (int j = 0; j < n; j++)
                if (j != i)
                    rowsum += (m[i][j] < 0) ? -m[i][j] : m[i][j];
            m[i][i] = int'(rowsum) + int'($urandom_range(8 * 65536, 65536));
        end
        bad = $urandom_range(n - 1);
        case (kind)
            SYS_ASYM:
                if (n > 1)
                    m[bad][(bad + 1) % n] += 1;
            SYS_INDEF:
                m[bad][bad] = ($urandom_range(1) == 0) ? 0 : -int'($urandom_range(65536 * 4));
            SYS_NOISE:
                for (int i = 0; i < n; i++)
                    for (int j = 0; j < n; j++)
                        m[i][j] = int'($urandom);
            default: ;
        endcase
        for (int i = 0; i < n; i++)
        begin
            for (int j = 0; j < n; j++)
                entry_queue.push_back(m[i][j]);
            entry_queue.push_back(b[i]);
        end
        systems_built++;
    endtask

    initial
    begin
        int unsigned n;
        int unsigned pick;
        int unsigned mark;
        sys_kind_t   kind;

        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        elem_value     = '0;
        out_stall      = 1'b0;
        offered        = 1'b0;
        cfg_done       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        errors         = 0;
        cycles         = 0;
        entries_taken  = 0;
        results_checked = 0;
        systems_built  = 0;
        size_reg       = 5'd16;
        entry_count    = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: single-unknown extremes, with size zero acting as one.
        write_size(5'd0);
        entry_queue.push_back(32'h7FFF_FFFF);
        entry_queue.push_back(32'h8000_0000);
        entry_queue.push_back(32'h8000_0000);
        entry_queue.push_back(32'h7FFF_FFFF);
        entry_queue.push_back(32'h0000_0000);
        entry_queue.push_back(32'h0001_0000);
        entry_queue.push_back(32'h0000_0001);
        entry_queue.push_back(32'hFFFF_FFFF);
        drain();

        // Directed: asymmetric and indefinite pairs, then an aborted partial load.
        write_size(5'd2);
        queue_system(2, SYS_ASYM);
        queue_system(2, SYS_INDEF);
        queue_system(2, SYS_SPD);
        drain();
        write_size(5'd3);
        for (int i = 0; i < 5; i++)
            entry_queue.push_back($urandom);
        drain();
        write_size(5'd2);
        queue_system(2, SYS_SPD);
        drain();

        // Directed: full size, including an oversize setting.
        write_size(5'd31);
        queue_system(MAX_N, SYS_SPD);
        drain();

        // Random: four idling phases, mostly small well-formed systems.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            for (int sub = 0; sub < 2; sub++)
            begin
                n = $urandom_range(4, 1);
                write_size(n[CFG_W-1:0]);
                mark = entries_taken + entry_queue.size();
                while (entries_taken + entry_queue.size() < mark + 4)
                begin
                    pick = $urandom_range(99);
                    kind = (pick < 70) ? SYS_SPD : (pick < 80) ? SYS_ASYM :
                           (pick < 90) ? SYS_INDEF : SYS_NOISE;
                    queue_system(n, kind);
                end
                drain();
            end
        end

        drain();
        $display("Run covered %0d systems over sizes 1 to %0d, %0d entries loaded,",
                 systems_built, MAX_N, entries_taken);
        $display("and %0d results checked under four idling patterns.", results_checked);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/chol_pkg.sv
hdl/chol_ram.sv
hdl/chol_dp.sv
hdl/chol_ctrl.sv
hdl/cholesky_linear_solver.sv
verif/tb.sv
